// ----- design/crs_pkg.sv -----
// ----------------------------------------------------------------------------
// Clip rectangle stack package
// Request and result types, the action codes and the stack entry layout.
// ----------------------------------------------------------------------------
package crs_pkg;

  // Action codes carried in the request.
  typedef enum logic [1:0] {
    ActBegin = 2'd0,
    ActPush  = 2'd1,
    ActPop   = 2'd2
  } action_e;

  // One request: an action and a rectangle.
  typedef struct packed {
    action_e            action;
    logic signed [31:0] rect_x;
    logic signed [31:0] rect_y;
    logic signed [31:0] rect_width;
    logic signed [31:0] rect_height;
  } req_t;

  // One result: the current clip rectangle and the action status.
  typedef struct packed {
    logic signed [31:0] clip_x;
    logic signed [31:0] clip_y;
    logic signed [31:0] clip_width;
    logic signed [31:0] clip_height;
    logic               clip_valid;
    logic               accepted;
    logic [4:0]         stack_depth;
    logic               overflow;
  } rsp_t;

  // One stack entry, also the layout of the current rectangle.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] w;
    logic signed [31:0] h;
    logic               usable;
  } entry_t;

endpackage

// ----- design/crs_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module crs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is enabled.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/clip_rect_stack_core.sv -----
// ----------------------------------------------------------------------------
// Clip rectangle stack core
// The result strobe of an accepted request is registered and rises in the next cycle.
// Throughput: one request per cycle; busy_o stays low, the result is never stalled.
// The entry below the top is prefetched from the stack RAM on every request.
// Reset clears the current rectangle, the entry count and the strobe; the
// stack RAM is not cleared, only entries below the count are ever used.
// ----------------------------------------------------------------------------
module clip_rect_stack_core #(
  parameter int STACK_DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  crs_pkg::req_t req_i,
  output logic          result_valid_o,
  output crs_pkg::rsp_t rsp_o
);
  import crs_pkg::*;

  localparam int CntW  = $clog2(STACK_DEPTH + 1);
  localparam int AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int EntW  = $bits(entry_t);

  entry_t            cur_q, cur_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              acc_q, acc_d;
  logic              ovf_q, ovf_d;
  logic              valid_q;
  logic              accept;
  logic              we;
  logic [AddrW-1:0]  waddr;
  entry_t            wdata;
  logic [CntW-1:0]   raddr_full;
  logic [EntW-1:0]   below_raw;
  entry_t            below;
  entry_t            given;
  entry_t            isect;
  logic signed [31:0] right, bottom, left, top;
  logic [CntW+4:0]   cnt_ext;

  // Right or bottom edge: origin plus size, saturated to 32 bits.
  function automatic logic signed [31:0] sat_end(input logic signed [31:0] o,
                                                 input logic signed [31:0] s);
    logic signed [32:0] e;
    e = {o[31], o} + {s[31], s};
    if (e[32] != e[31]) begin
      sat_end = e[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat_end = e[31:0];
    end
  endfunction

  assign busy_o = 1'b0;
  assign accept = start_i;

  // The given rectangle as an entry.
  always_comb begin
    given.x      = req_i.rect_x;
    given.y      = req_i.rect_y;
    given.w      = req_i.rect_width;
    given.h      = req_i.rect_height;
    given.usable = (req_i.rect_width > 32'sd0) && (req_i.rect_height > 32'sd0);
  end

  // Intersection of the current rectangle with the given one.
  always_comb begin
    logic signed [31:0] rc, rg, bc, bg;
    rc     = sat_end(cur_q.x, cur_q.w);
    rg     = sat_end(given.x, given.w);
    bc     = sat_end(cur_q.y, cur_q.h);
    bg     = sat_end(given.y, given.h);
    right  = (rc < rg) ? rc : rg;
    bottom = (bc < bg) ? bc : bg;
    left   = (cur_q.x > given.x) ? cur_q.x : given.x;
    top    = (cur_q.y > given.y) ? cur_q.y : given.y;
    isect.x = left;
    isect.y = top;
    if ((right <= left) || (bottom <= top)) begin
      isect.w      = 32'sd0;
      isect.h      = 32'sd0;
      isect.usable = 1'b0;
    end else begin
      isect.w      = right - left;
      isect.h      = bottom - top;
      isect.usable = 1'b1;
    end
  end

  // Stack RAM; the read always fetches the entry below the next top.
  assign raddr_full = cnt_d - CntW'(2);
  assign below      = entry_t'(below_raw);

  crs_ram #(
    .Width (EntW),
    .Depth (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (raddr_full[AddrW-1:0]),
    .rdata_o (below_raw)
  );

  // Next state for one request.
  always_comb begin
    cur_d = cur_q;
    cnt_d = cnt_q;
    acc_d = 1'b0;
    ovf_d = 1'b0;
    we    = 1'b0;
    waddr = cnt_q[AddrW-1:0];
    wdata = given;
    case (req_i.action)
      ActBegin: begin
        cur_d = given;
        acc_d = given.usable;
        waddr = '0;
        if (given.usable) begin
          cnt_d = CntW'(1);
          we    = accept;
        end else begin
          cnt_d = '0;
        end
      end
      ActPush: begin
        if (cnt_q == CntW'(STACK_DEPTH)) begin
          ovf_d = 1'b1;
        end else if ((cnt_q != '0) && !cur_q.usable) begin
          // An unusable top is repeated.
          wdata = cur_q;
          we    = accept;
          cnt_d = cnt_q + CntW'(1);
        end else begin
          wdata = cur_q.usable ? isect : given;
          cur_d = wdata;
          acc_d = wdata.usable;
          we    = accept;
          cnt_d = cnt_q + CntW'(1);
        end
      end
      ActPop: begin
        if (cnt_q == '0) begin
          cur_d = '0;
        end else begin
          cnt_d = cnt_q - CntW'(1);
          acc_d = 1'b1;
          if (cnt_q == CntW'(1)) begin
            cur_d = '0;
          end else begin
            cur_d = below;
          end
        end
      end
      default: begin
        // Unused code: state unchanged, status flags low.
      end
    endcase
  end

  // State and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      cnt_q   <= '0;
      acc_q   <= 1'b0;
      ovf_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
      if (accept) begin
        cur_q <= cur_d;
        cnt_q <= cnt_d;
        acc_q <= acc_d;
        ovf_q <= ovf_d;
      end
    end
  end

  // Result fields come straight from the state registers.
  assign cnt_ext = (CntW + 5)'(cnt_q);

  always_comb begin
    rsp_o.clip_x      = cur_q.x;
    rsp_o.clip_y      = cur_q.y;
    rsp_o.clip_width  = cur_q.w;
    rsp_o.clip_height = cur_q.h;
    rsp_o.clip_valid  = cur_q.usable;
    rsp_o.accepted    = acc_q;
    rsp_o.stack_depth = cnt_ext[4:0];
    rsp_o.overflow    = ovf_q;
  end

  assign result_valid_o = valid_q;

endmodule
